[rtl/jbt_pkg.sv]
`timescale 1ns / 1ps

package jbt_pkg;

	// one byte of JSON text
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} byte_item_t;

	// one token, or one error report
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [31:0] token_offset;
		logic [12:0] token_length;
		logic [2:0]  error_cause;
		logic        last_of_run;
	} token_item_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STRING,
		MODE_KEYWORD,
		MODE_NUMBER,
		MODE_SKIP
	} mode_t;

	// scanner control state
	typedef struct packed {
		mode_t      mode;
		logic       esc;
		logic [1:0] kw_id;
		logic [2:0] kw_idx;
	} lex_ctl_t;

	localparam logic [3:0] KIND_LBRACE   = 4'd0;
	localparam logic [3:0] KIND_RBRACE   = 4'd1;
	localparam logic [3:0] KIND_LBRACKET = 4'd2;
	localparam logic [3:0] KIND_RBRACKET = 4'd3;
	localparam logic [3:0] KIND_COLON    = 4'd4;
	localparam logic [3:0] KIND_COMMA    = 4'd5;
	localparam logic [3:0] KIND_STRING   = 4'd6;
	localparam logic [3:0] KIND_TRUE     = 4'd7;
	localparam logic [3:0] KIND_NUMBER   = 4'd10;
	localparam logic [3:0] KIND_ERROR    = 4'd11;

	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_BAD     = 3'd1;
	localparam logic [2:0] CAUSE_KEYWORD = 3'd2;
	localparam logic [2:0] CAUSE_UNTERM  = 3'd3;
	localparam logic [2:0] CAUSE_LONG    = 3'd4;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_LOWER_E  = 8'h65;
	localparam logic [7:0] CH_UPPER_E  = 8'h45;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_LOWER_T  = 8'h74;
	localparam logic [7:0] CH_LOWER_F  = 8'h66;
	localparam logic [7:0] CH_LOWER_N  = 8'h6E;

	// result queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

	function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (id)
			KW_TRUE: begin
				unique case (idx)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			KW_FALSE: begin
				unique case (idx)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			KW_NULL: begin
				unique case (idx)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] id);
		return (id == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_number_byte(input logic [7:0] b);
		return is_digit(b) || b == CH_MINUS || b == CH_PLUS || b == CH_DOT ||
			b == CH_LOWER_E || b == CH_UPPER_E;
	endfunction

	function automatic token_item_t make_item(input logic [3:0] kind, input logic [31:0] off,
		input logic [12:0] len, input logic [2:0] cause);
		token_item_t t;
		t.token_kind   = kind;
		t.token_offset = off;
		t.token_length = len;
		t.error_cause  = cause;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

endpackage

[rtl/jbt_lexer.sv]
`timescale 1ns / 1ps

// One scanner step: next state and up to two tokens for one byte.
module jbt_lexer #(
	parameter int unsigned MAX_TOKEN_LEN = 4096,
	parameter int unsigned POSITION_BITS = 32,
	localparam int unsigned LEN_BITS = $clog2(MAX_TOKEN_LEN + 1)
) (
	input  logic [7:0]             data_byte,
	input  logic                   eof,
	input  jbt_pkg::lex_ctl_t      ctl,
	input  logic [POSITION_BITS-1:0] tok_start,
	input  logic [LEN_BITS-1:0]    len,
	input  logic [POSITION_BITS-1:0] pos,
	output jbt_pkg::lex_ctl_t      ctl_nxt,
	output logic [POSITION_BITS-1:0] tok_start_nxt,
	output logic [LEN_BITS-1:0]    len_nxt,
	output logic [POSITION_BITS-1:0] pos_nxt,
	output logic [1:0]             res_cnt,
	output jbt_pkg::token_item_t   res0,
	output jbt_pkg::token_item_t   res1
);
	import jbt_pkg::*;

	logic [POSITION_BITS+31:0] pos_wide, tok_wide;
	logic [31:0]               pos32, tok32;
	logic [LEN_BITS-1:0]       len_inc;
	logic [LEN_BITS+12:0]      len_wide, len_inc_wide;
	logic [12:0]               len13, len_inc13;
	logic [POSITION_BITS-1:0]  pos_inc;
	logic [1:0]                kid;
	logic [2:0]                kidx_inc;

	// start-of-token decode, with the mode already back at idle
	logic                     s_emit;
	token_item_t              s_item;
	lex_ctl_t                 s_ctl;
	logic [POSITION_BITS-1:0] s_tok;
	logic [LEN_BITS-1:0]      s_len;

	assign pos_wide     = {32'b0, pos};
	assign tok_wide     = {32'b0, tok_start};
	assign pos32        = pos_wide[31:0];
	assign tok32        = tok_wide[31:0];
	assign len_inc      = len + 1'b1;
	assign len_wide     = {13'b0, len};
	assign len_inc_wide = {13'b0, len_inc};
	assign len13        = len_wide[12:0];
	assign len_inc13    = len_inc_wide[12:0];
	assign pos_inc      = pos + 1'b1;
	assign kid          = (ctl.kw_id == 2'd3) ? KW_TRUE : ctl.kw_id;
	assign kidx_inc     = ctl.kw_idx + 1'b1;

	always_comb begin
		s_emit   = 1'b0;
		s_item   = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_NONE);
		s_ctl    = ctl;
		s_ctl.mode = MODE_IDLE;
		s_tok    = tok_start;
		s_len    = len;
		unique case (data_byte)
			CH_SPACE, CH_LF, CH_CR, CH_TAB: begin
			end
			CH_LBRACE: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_LBRACE, pos32, 13'd1, CAUSE_NONE);
			end
			CH_RBRACE: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_RBRACE, pos32, 13'd1, CAUSE_NONE);
			end
			CH_LBRACKET: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_LBRACKET, pos32, 13'd1, CAUSE_NONE);
			end
			CH_RBRACKET: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_RBRACKET, pos32, 13'd1, CAUSE_NONE);
			end
			CH_COLON: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_COLON, pos32, 13'd1, CAUSE_NONE);
			end
			CH_COMMA: begin
				s_emit = 1'b1;
				s_item = make_item(KIND_COMMA, pos32, 13'd1, CAUSE_NONE);
			end
			CH_QUOTE: begin
				if (eof) begin
					s_emit = 1'b1;
					s_item = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_UNTERM);
				end else begin
					s_ctl.mode = MODE_STRING;
					s_ctl.esc  = 1'b0;
					s_tok      = pos_inc;
					s_len      = '0;
				end
			end
			CH_LOWER_T, CH_LOWER_F, CH_LOWER_N: begin
				if (eof) begin
					s_emit = 1'b1;
					s_item = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_UNTERM);
				end else begin
					s_ctl.mode   = MODE_KEYWORD;
					s_ctl.kw_id  = (data_byte == CH_LOWER_T) ? KW_TRUE :
						((data_byte == CH_LOWER_F) ? KW_FALSE : KW_NULL);
					s_ctl.kw_idx = 3'd1;
					s_tok        = pos;
				end
			end
			default: begin
				if (data_byte == CH_MINUS || data_byte == CH_PLUS || is_digit(data_byte)) begin
					if (eof) begin
						s_emit = 1'b1;
						s_item = make_item(KIND_NUMBER, pos32, 13'd1, CAUSE_NONE);
					end else begin
						s_ctl.mode = MODE_NUMBER;
						s_tok      = pos;
						s_len      = LEN_BITS'(1);
					end
				end else begin
					s_emit     = 1'b1;
					s_item     = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_BAD);
					s_ctl.mode = eof ? MODE_IDLE : MODE_SKIP;
				end
			end
		endcase
	end

	always_comb begin
		ctl_nxt       = ctl;
		tok_start_nxt = tok_start;
		len_nxt       = len;
		res_cnt       = 2'd0;
		res0          = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_NONE);
		res1          = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_NONE);
		unique case (ctl.mode)
			MODE_IDLE: begin
				ctl_nxt       = s_ctl;
				tok_start_nxt = s_tok;
				len_nxt       = s_len;
				res_cnt       = {1'b0, s_emit};
				res0          = s_item;
			end
			MODE_STRING: begin
				if (!ctl.esc && data_byte == CH_QUOTE) begin
					res_cnt      = 2'd1;
					res0         = make_item(KIND_STRING, tok32, len13, CAUSE_NONE);
					ctl_nxt.mode = MODE_IDLE;
				end else if (len >= LEN_BITS'(MAX_TOKEN_LEN)) begin
					res_cnt      = 2'd1;
					res0         = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_LONG);
					ctl_nxt.mode = eof ? MODE_IDLE : MODE_SKIP;
				end else begin
					// backslash toggles escape; any byte after an escape clears it
					if (ctl.esc || data_byte == CH_BSLASH)
						ctl_nxt.esc = ~ctl.esc;
					len_nxt = len_inc;
					if (eof) begin
						res_cnt      = 2'd1;
						res0         = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_UNTERM);
						ctl_nxt.mode = MODE_IDLE;
					end
				end
			end
			MODE_KEYWORD: begin
				if (ctl.kw_idx >= kw_len(kid) || kw_char(kid, ctl.kw_idx) != data_byte) begin
					res_cnt      = 2'd1;
					res0         = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_KEYWORD);
					ctl_nxt.mode = eof ? MODE_IDLE : MODE_SKIP;
				end else begin
					ctl_nxt.kw_idx = kidx_inc;
					if (kidx_inc == kw_len(kid)) begin
						res_cnt      = 2'd1;
						res0         = make_item(KIND_TRUE + {2'b00, kid}, tok32,
							{10'd0, kidx_inc}, CAUSE_NONE);
						ctl_nxt.mode = MODE_IDLE;
					end else if (eof) begin
						res_cnt      = 2'd1;
						res0         = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_UNTERM);
						ctl_nxt.mode = MODE_IDLE;
					end
				end
			end
			MODE_NUMBER: begin
				if (is_number_byte(data_byte)) begin
					if (len >= LEN_BITS'(MAX_TOKEN_LEN)) begin
						res_cnt      = 2'd1;
						res0         = make_item(KIND_ERROR, pos32, 13'd0, CAUSE_LONG);
						ctl_nxt.mode = eof ? MODE_IDLE : MODE_SKIP;
					end else begin
						len_nxt = len_inc;
						if (eof) begin
							res_cnt      = 2'd1;
							res0         = make_item(KIND_NUMBER, tok32, len_inc13, CAUSE_NONE);
							ctl_nxt.mode = MODE_IDLE;
						end
					end
				end else begin
					// number closes, then the ending byte starts its own token
					res0          = make_item(KIND_NUMBER, tok32, len13, CAUSE_NONE);
					res1          = s_item;
					res_cnt       = s_emit ? 2'd2 : 2'd1;
					ctl_nxt       = s_ctl;
					tok_start_nxt = s_tok;
					len_nxt       = s_len;
				end
			end
			default: begin
			end
		endcase

		if (eof) begin
			ctl_nxt.mode = MODE_IDLE;
			ctl_nxt.esc  = 1'b0;
			pos_nxt      = '0;
		end else begin
			pos_nxt = pos_inc;
		end

		if (res_cnt == 2'd1)
			res0.last_of_run = 1'b1;
		if (res_cnt == 2'd2)
			res1.last_of_run = 1'b1;
	end

endmodule

[rtl/jbt_out_fifo.sv]
`timescale 1ns / 1ps

// Small token queue: up to two writes per cycle, one read.
module jbt_out_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               push_cnt,
	input  jbt_pkg::token_item_t     push0,
	input  jbt_pkg::token_item_t     push1,
	input  logic                     pop,
	output jbt_pkg::token_item_t     head,
	output logic                     head_valid,
	output logic [jbt_pkg::FIFO_PTR_W:0] fill
);
	import jbt_pkg::*;

	token_item_t           mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q, wr_nxt;
	logic [FIFO_PTR_W:0]   fill_q;

	assign wr_nxt     = wr_q + 1'b1;
	assign head       = mem_q[rd_q];
	assign head_valid = (fill_q != '0);
	assign fill       = fill_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_nxt] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + FIFO_PTR_W'(push_cnt);
			rd_q   <= rd_q + FIFO_PTR_W'(pop);
			fill_q <= fill_q + (FIFO_PTR_W + 1)'(push_cnt) - (FIFO_PTR_W + 1)'(pop);
		end
	end

endmodule

[rtl/json_byte_tokenizer.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Item
// byte      in   byte_valid/stall    byte_item  (data_byte, end_of_input)
// token     out  token_valid/stall   token_item (kind, offset, length, cause, last)
//
// One byte is taken per cycle while byte_stall is low. A byte sits in the input
// register while the scanner works on it; its tokens enter a four-entry queue
// whose head drives the output. A number closed by a punctuation mark gives two
// tokens; the queue absorbs that, and the input stalls once the queue holds more
// than two tokens.
// The input stalls while the held byte cannot place its two possible tokens.
// Reset clears scanner state, byte position and the queue.
module json_byte_tokenizer #(
	parameter int unsigned MAX_TOKEN_LEN = 4096,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  jbt_pkg::byte_item_t  byte_item,
	output logic                 token_valid,
	input  logic                 token_stall,
	output jbt_pkg::token_item_t token_item
);
	import jbt_pkg::*;

	localparam int unsigned LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

	// input register
	byte_item_t in_s1;
	logic       valid_s1;

	// scanner state
	lex_ctl_t                 ctl_q, ctl_nxt;
	logic [POSITION_BITS-1:0] tok_start_q, tok_start_nxt;
	logic [LEN_BITS-1:0]      len_q, len_nxt;
	logic [POSITION_BITS-1:0] pos_q, pos_nxt;

	logic [1:0]          res_cnt;
	token_item_t         res0, res1;
	logic [FIFO_PTR_W:0] fill;
	logic                room, go, take;

	// room for two tokens, whatever the held byte turns out to need
	assign room       = fill <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2);
	assign go         = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk) begin
		if (take)
			in_s1 <= byte_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode   <= MODE_IDLE;
			ctl_q.esc    <= 1'b0;
			ctl_q.kw_id  <= KW_TRUE;
			ctl_q.kw_idx <= '0;
			tok_start_q  <= '0;
			len_q        <= '0;
			pos_q        <= '0;
		end else if (go) begin
			ctl_q       <= ctl_nxt;
			tok_start_q <= tok_start_nxt;
			len_q       <= len_nxt;
			pos_q       <= pos_nxt;
		end
	end

	jbt_lexer #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.POSITION_BITS (POSITION_BITS)
	) u_lexer (
		.data_byte     (in_s1.data_byte),
		.eof           (in_s1.end_of_input),
		.ctl           (ctl_q),
		.tok_start     (tok_start_q),
		.len           (len_q),
		.pos           (pos_q),
		.ctl_nxt       (ctl_nxt),
		.tok_start_nxt (tok_start_nxt),
		.len_nxt       (len_nxt),
		.pos_nxt       (pos_nxt),
		.res_cnt       (res_cnt),
		.res0          (res0),
		.res1          (res1)
	);

	jbt_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (go ? res_cnt : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.pop        (token_valid && !token_stall),
		.head       (token_item),
		.head_valid (token_valid),
		.fill       (fill)
	);

	// queue never holds more than its depth
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
		else $error("token queue overflow");

	// error tokens and only error tokens carry a cause
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ((token_item.token_kind == KIND_ERROR) ==
			(token_item.error_cause != CAUSE_NONE)))
		else $error("error cause mismatch");

	// position restarts after the last byte of a text
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go && in_s1.end_of_input |=> pos_q == '0)
		else $error("position not cleared at end of input");

	// skipped bytes after an error give no tokens
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		go && ctl_q.mode == MODE_SKIP |-> res_cnt == 2'd0)
		else $error("token emitted while skipping");

endmodule
